/* rtl/core/status_led_blink_controller_macros.svh */
// Assertion macros for the status LED blink controller.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef STATUS_LED_BLINK_CONTROLLER_MACROS_SVH
`define STATUS_LED_BLINK_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbc assertion failed");

// Next-cycle implication, disabled during reset.
`define SLBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbc assertion failed");

`endif

/* rtl/core/slbc_pkg.sv */
// Package for the status LED blink controller: payload and config types,
// register indexes, reset values and default tick lengths. No dependencies.
`default_nettype none

package slbc_pkg;

  localparam int TICK_MS_DEF       = 10;
  localparam int SLEEP_TICK_MS_DEF = 1000;

  localparam int UPTIME_W = 17;
  localparam int TIMER_W  = 16;
  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [UPTIME_W-1:0] UPTIME_MAX = '1;
  localparam logic [TIMER_W-1:0]  TIMER_MAX  = '1;

  // LED mode codes; any code at or above MODE_FLASH flashes
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLASH = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_NET_MODE  = 3'd0;
  localparam logic [2:0] REG_POS_MODE  = 3'd1;
  localparam logic [2:0] REG_PWR_EN    = 3'd2;
  localparam logic [2:0] REG_QUICK     = 3'd3;
  localparam logic [2:0] REG_SLOW_ON   = 3'd4;
  localparam logic [2:0] REG_SLOW_OFF  = 3'd5;
  localparam logic [2:0] REG_STARTUP   = 3'd6;

  localparam logic [TIMER_W-1:0] QUICK_RST    = 16'd100;
  localparam logic [TIMER_W-1:0] SLOW_ON_RST  = 16'd100;
  localparam logic [TIMER_W-1:0] SLOW_OFF_RST = 16'd1900;
  localparam logic [TIMER_W-1:0] STARTUP_RST  = 16'd7000;

  typedef struct packed {
    logic asleep;
    logic battery_low_alarm;
    logic charging;
    logic battery_full;
  } slbc_in_t;

  typedef struct packed {
    logic network_led;
    logic position_led;
    logic power_led;
  } slbc_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]  network_led_mode;
    logic [MODE_W-1:0]  position_led_mode;
    logic               power_led_enable;
    logic [TIMER_W-1:0] quick_flash_ms;
    logic [TIMER_W-1:0] slow_on_ms;
    logic [TIMER_W-1:0] slow_off_ms;
    logic [TIMER_W-1:0] startup_flash_ms;
  } slbc_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/slbc_cfg_regs.sv */
// APB-style configuration register file for the status LED blink controller.
// Depends on slbc_pkg.
`default_nettype none

module slbc_cfg_regs import slbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output slbc_cfg_t              cfg
);

  slbc_cfg_t  cfg_r;
  slbc_cfg_t  cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_NET_MODE: cfg_nxt.network_led_mode  = pwdata[MODE_W-1:0];
        REG_POS_MODE: cfg_nxt.position_led_mode = pwdata[MODE_W-1:0];
        REG_PWR_EN:   cfg_nxt.power_led_enable  = pwdata[0];
        REG_QUICK:    cfg_nxt.quick_flash_ms    = pwdata[TIMER_W-1:0];
        REG_SLOW_ON:  cfg_nxt.slow_on_ms        = pwdata[TIMER_W-1:0];
        REG_SLOW_OFF: cfg_nxt.slow_off_ms       = pwdata[TIMER_W-1:0];
        REG_STARTUP:  cfg_nxt.startup_flash_ms  = pwdata[TIMER_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NET_MODE: prdata = DATA_W'(cfg_r.network_led_mode);
      REG_POS_MODE: prdata = DATA_W'(cfg_r.position_led_mode);
      REG_PWR_EN:   prdata = DATA_W'(cfg_r.power_led_enable);
      REG_QUICK:    prdata = DATA_W'(cfg_r.quick_flash_ms);
      REG_SLOW_ON:  prdata = DATA_W'(cfg_r.slow_on_ms);
      REG_SLOW_OFF: prdata = DATA_W'(cfg_r.slow_off_ms);
      REG_STARTUP:  prdata = DATA_W'(cfg_r.startup_flash_ms);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.network_led_mode  <= MODE_FLASH;
      cfg_r.position_led_mode <= MODE_FLASH;
      cfg_r.power_led_enable  <= 1'b0;
      cfg_r.quick_flash_ms    <= QUICK_RST;
      cfg_r.slow_on_ms        <= SLOW_ON_RST;
      cfg_r.slow_off_ms       <= SLOW_OFF_RST;
      cfg_r.startup_flash_ms  <= STARTUP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/slbc_led_core.sv */
// LED state engine: uptime counter, three LED timers and lit flags, updated
// once per tick. Depends on slbc_pkg.
`default_nettype none

module slbc_led_core import slbc_pkg::*; #(
  parameter int TICK_MS       = TICK_MS_DEF,
  parameter int SLEEP_TICK_MS = SLEEP_TICK_MS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  slbc_in_t       tick,
  input  slbc_cfg_t      cfg,
  output slbc_out_t      leds_nxt
);

  localparam int UP_SUM_W = UPTIME_W + 1;
  localparam int TM_SUM_W = TIMER_W + 1;

  logic [UPTIME_W-1:0] uptime_r,  uptime_nxt;
  logic [TIMER_W-1:0]  net_tmr_r, net_tmr_nxt;
  logic [TIMER_W-1:0]  pos_tmr_r, pos_tmr_nxt;
  logic [TIMER_W-1:0]  pwr_tmr_r, pwr_tmr_nxt;
  logic net_lit_r, net_lit_nxt;
  logic net_pin_r, net_pin_nxt;
  logic pos_lit_r, pos_lit_nxt;
  logic pwr_lit_r, pwr_lit_nxt;

  logic [UP_SUM_W-1:0] up_sum;
  logic [TM_SUM_W-1:0] net_sum, pos_sum, pwr_sum;
  logic [TIMER_W-1:0]  net_t, pos_t, pwr_t;
  logic [TM_SUM_W-1:0] long_ms;

  always_comb begin
    up_sum  = {1'b0, uptime_r} +
              (tick.asleep ? UP_SUM_W'(SLEEP_TICK_MS) : UP_SUM_W'(TICK_MS));
    uptime_nxt = (up_sum > {1'b0, UPTIME_MAX}) ? UPTIME_MAX : up_sum[UPTIME_W-1:0];

    net_sum = {1'b0, net_tmr_r} + TM_SUM_W'(TICK_MS);
    pos_sum = {1'b0, pos_tmr_r} + TM_SUM_W'(TICK_MS);
    pwr_sum = {1'b0, pwr_tmr_r} + TM_SUM_W'(TICK_MS);
    net_t   = (net_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : net_sum[TIMER_W-1:0];
    pos_t   = (pos_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : pos_sum[TIMER_W-1:0];
    pwr_t   = (pwr_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : pwr_sum[TIMER_W-1:0];
    long_ms = {1'b0, cfg.quick_flash_ms} + {1'b0, cfg.slow_off_ms};
  end

  // network LED
  always_comb begin
    net_lit_nxt = net_lit_r;
    net_pin_nxt = net_pin_r;
    net_tmr_nxt = net_t;
    priority if (tick.asleep) begin
      net_pin_nxt = 1'b0;
    end else if (uptime_nxt < {1'b0, cfg.startup_flash_ms}) begin
      if (net_t >= cfg.quick_flash_ms) begin
        net_lit_nxt = !net_lit_r;
        net_pin_nxt = !net_lit_r;
        net_tmr_nxt = '0;
      end
    end else if (cfg.network_led_mode < MODE_FLASH) begin
      net_lit_nxt = (cfg.network_led_mode == MODE_ON);
      net_pin_nxt = (cfg.network_led_mode == MODE_ON);
      net_tmr_nxt = '0;
    end else if (net_lit_r && net_t >= cfg.slow_on_ms) begin
      net_lit_nxt = 1'b0;
      net_pin_nxt = 1'b0;
      net_tmr_nxt = '0;
    end else if (!net_lit_r && net_t >= cfg.slow_off_ms) begin
      net_lit_nxt = 1'b1;
      net_pin_nxt = 1'b1;
      net_tmr_nxt = '0;
    end else begin
      net_tmr_nxt = net_t;
    end
  end

  // position LED
  always_comb begin
    pos_lit_nxt = pos_lit_r;
    pos_tmr_nxt = pos_t;
    priority if (cfg.position_led_mode < MODE_FLASH) begin
      pos_lit_nxt = (cfg.position_led_mode == MODE_ON);
      pos_tmr_nxt = '0;
    end else if (pos_t >= cfg.quick_flash_ms) begin
      pos_lit_nxt = !pos_lit_r;
      pos_tmr_nxt = '0;
    end else begin
      pos_tmr_nxt = pos_t;
    end
  end

  // power LED, frozen while disabled
  always_comb begin
    pwr_lit_nxt = pwr_lit_r;
    pwr_tmr_nxt = pwr_tmr_r;
    if (cfg.power_led_enable) begin
      pwr_tmr_nxt = pwr_t;
      priority if (tick.asleep) begin
        pwr_lit_nxt = 1'b0;
        pwr_tmr_nxt = '0;
      end else if (tick.battery_low_alarm && !tick.charging) begin
        if (pwr_t >= cfg.quick_flash_ms) begin
          pwr_lit_nxt = !pwr_lit_r;
          pwr_tmr_nxt = '0;
        end
      end else if (tick.battery_full && tick.charging) begin
        if ({1'b0, pwr_t} >= long_ms) begin
          pwr_lit_nxt = !pwr_lit_r;
          pwr_tmr_nxt = '0;
        end
      end else if (tick.charging) begin
        pwr_lit_nxt = 1'b1;
        pwr_tmr_nxt = '0;
      end else if (pwr_lit_r && pwr_t >= cfg.quick_flash_ms) begin
        pwr_lit_nxt = 1'b0;
        pwr_tmr_nxt = '0;
      end else if ({1'b0, pwr_t} >= long_ms) begin
        pwr_lit_nxt = !pwr_lit_r;
        pwr_tmr_nxt = '0;
      end else begin
        pwr_tmr_nxt = pwr_t;
      end
    end
  end

  assign leds_nxt.network_led  = net_pin_nxt;
  assign leds_nxt.position_led = pos_lit_nxt;
  assign leds_nxt.power_led    = pwr_lit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r  <= '0;
      net_tmr_r <= '0;
      pos_tmr_r <= '0;
      pwr_tmr_r <= '0;
      net_lit_r <= 1'b0;
      net_pin_r <= 1'b0;
      pos_lit_r <= 1'b0;
      pwr_lit_r <= 1'b0;
    end else if (step) begin
      uptime_r  <= uptime_nxt;
      net_tmr_r <= net_tmr_nxt;
      pos_tmr_r <= pos_tmr_nxt;
      pwr_tmr_r <= pwr_tmr_nxt;
      net_lit_r <= net_lit_nxt;
      net_pin_r <= net_pin_nxt;
      pos_lit_r <= pos_lit_nxt;
      pwr_lit_r <= pwr_lit_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/status_led_blink_controller.sv */
// Status LED blink controller. One tick transfer per clock is accepted while
// in_stall is low, and each yields one transfer of three LED pin levels. A tick
// is captured in an input register, the LED state is updated from it and the
// levels land in an output register, so out_valid rises when the output
// register is loaded from the input register, which out_stall can hold off;
// the sustained rate is one tick per cycle while out_stall is low. in_stall
// rises only while the output register holds an untaken result and the input
// register is full.
// Depends on slbc_pkg, slbc_cfg_regs, slbc_led_core and the macros header.
`default_nettype none

`include "status_led_blink_controller_macros.svh"

module status_led_blink_controller import slbc_pkg::*; #(
  parameter int TICK_MS       = TICK_MS_DEF,
  parameter int SLEEP_TICK_MS = SLEEP_TICK_MS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  slbc_in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output slbc_out_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  slbc_cfg_t cfg;
  slbc_in_t  in_r;
  slbc_out_t out_r;
  slbc_out_t leds_nxt;
  logic      in_valid_r;
  logic      out_valid_r;
  logic      advance;
  logic      step;

  slbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slbc_led_core #(
    .TICK_MS       (TICK_MS),
    .SLEEP_TICK_MS (SLEEP_TICK_MS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .tick     (in_r),
    .cfg      (cfg),
    .leds_nxt (leds_nxt)
  );

  assign advance   = !out_valid_r || !out_stall;
  assign step      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (step) begin
      out_r <= leds_nxt;
    end
  end

  `SLBC_ASSERT_NOW(a_no_stall_when_out_free, !out_valid_r, !in_stall)
  `SLBC_ASSERT_NEXT(a_step_loads_out, step, out_valid_r)
  `SLBC_ASSERT_NEXT(a_pwr_frozen_when_off, step && !cfg.power_led_enable && out_valid_r,
                    out_r.power_led == $past(out_r.power_led))

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for status_led_blink_controller: drives tick transfers and APB
// register writes, predicts the three LED pins per tick and checks each result.
// Depends on slbc_pkg and the RTL under rtl/core.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slbc_pkg::*;

  localparam logic [2:0]        REG_SPARE   = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam int                CYCLE_LIMIT = 1_000_000;

  class led_pin_tracker;
    localparam int PRINT_CAP = 100;

    slbc_cfg_t           cfg;
    logic [UPTIME_W-1:0] uptime;
    logic [TIMER_W-1:0]  net_timer, pos_timer, pwr_timer;
    logic                net_lit, net_pin, pos_lit, pwr_lit;
    slbc_out_t           expected_pins[$];
    int unsigned         pins_seen;
    int unsigned         mismatches;

    function void clear();
      cfg.network_led_mode  = MODE_FLASH;
      cfg.position_led_mode = MODE_FLASH;
      cfg.power_led_enable  = 1'b0;
      cfg.quick_flash_ms    = QUICK_RST;
      cfg.slow_on_ms        = SLOW_ON_RST;
      cfg.slow_off_ms       = SLOW_OFF_RST;
      cfg.startup_flash_ms  = STARTUP_RST;
      uptime    = '0;
      net_timer = '0;
      pos_timer = '0;
      pwr_timer = '0;
      net_lit   = 1'b0;
      net_pin   = 1'b0;
      pos_lit   = 1'b0;
      pwr_lit   = 1'b0;
      expected_pins.delete();
      pins_seen  = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_NET_MODE: cfg.network_led_mode  = v[MODE_W-1:0];
        REG_POS_MODE: cfg.position_led_mode = v[MODE_W-1:0];
        REG_PWR_EN:   cfg.power_led_enable  = v[0];
        REG_QUICK:    cfg.quick_flash_ms    = v[TIMER_W-1:0];
        REG_SLOW_ON:  cfg.slow_on_ms        = v[TIMER_W-1:0];
        REG_SLOW_OFF: cfg.slow_off_ms       = v[TIMER_W-1:0];
        REG_STARTUP:  cfg.startup_flash_ms  = v[TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_NET_MODE: return DATA_W'(cfg.network_led_mode);
        REG_POS_MODE: return DATA_W'(cfg.position_led_mode);
        REG_PWR_EN:   return DATA_W'(cfg.power_led_enable);
        REG_QUICK:    return DATA_W'(cfg.quick_flash_ms);
        REG_SLOW_ON:  return DATA_W'(cfg.slow_on_ms);
        REG_SLOW_OFF: return DATA_W'(cfg.slow_off_ms);
        REG_STARTUP:  return DATA_W'(cfg.startup_flash_ms);
        default:      return '0;
      endcase
    endfunction

    function int unsigned sat_sum(int unsigned a, int unsigned b, int unsigned lim);
      return (a + b > lim) ? lim : a + b;
    endfunction

    function slbc_out_t advance_leds(slbc_in_t t);
      int unsigned quick, long_ms, nt, qt, wt;
      slbc_out_t   pins;
      quick   = cfg.quick_flash_ms;
      long_ms = quick + 32'(cfg.slow_off_ms);
      uptime  = UPTIME_W'(sat_sum(uptime, t.asleep ? SLEEP_TICK_MS_DEF : TICK_MS_DEF,
                                  UPTIME_MAX));

      nt = sat_sum(net_timer, TICK_MS_DEF, TIMER_MAX);
      if (t.asleep) begin
        net_pin = 1'b0;
      end else if (uptime < cfg.startup_flash_ms) begin
        if (nt >= quick) begin
          net_lit = !net_lit;
          net_pin = net_lit;
          nt      = 0;
        end
      end else if (cfg.network_led_mode < MODE_FLASH) begin
        net_lit = (cfg.network_led_mode == MODE_ON);
        net_pin = net_lit;
        nt      = 0;
      end else if (net_lit && nt >= cfg.slow_on_ms) begin
        net_lit = 1'b0;
        net_pin = 1'b0;
        nt      = 0;
      end else if (!net_lit && nt >= cfg.slow_off_ms) begin
        net_lit = 1'b1;
        net_pin = 1'b1;
        nt      = 0;
      end
      net_timer = TIMER_W'(nt);

      qt = sat_sum(pos_timer, TICK_MS_DEF, TIMER_MAX);
      if (cfg.position_led_mode < MODE_FLASH) begin
        pos_lit = (cfg.position_led_mode == MODE_ON);
        qt      = 0;
      end else if (qt >= quick) begin
        pos_lit = !pos_lit;
        qt      = 0;
      end
      pos_timer = TIMER_W'(qt);

      // power state freezes while the power LED is disabled
      if (cfg.power_led_enable) begin
        wt = sat_sum(pwr_timer, TICK_MS_DEF, TIMER_MAX);
        if (t.asleep) begin
          pwr_lit = 1'b0;
          wt      = 0;
        end else if (t.battery_low_alarm && !t.charging) begin
          if (wt >= quick) begin
            pwr_lit = !pwr_lit;
            wt      = 0;
          end
        end else if (t.battery_full && t.charging) begin
          if (wt >= long_ms) begin
            pwr_lit = !pwr_lit;
            wt      = 0;
          end
        end else if (t.charging) begin
          pwr_lit = 1'b1;
          wt      = 0;
        end else if (pwr_lit && wt >= quick) begin
          pwr_lit = 1'b0;
          wt      = 0;
        end else if (wt >= long_ms) begin
          pwr_lit = !pwr_lit;
          wt      = 0;
        end
        pwr_timer = TIMER_W'(wt);
      end

      pins.network_led  = net_pin;
      pins.position_led = pos_lit;
      pins.power_led    = pwr_lit;
      return pins;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH: %s", msg);
    endtask

    function void note_tick(slbc_in_t t);
      expected_pins.push_back(advance_leds(t));
    endfunction

    task check_pins(slbc_out_t got);
      slbc_out_t want;
      if (expected_pins.size() == 0) begin
        report($sformatf("result with no tick pending, pins %b", got));
        return;
      end
      want = expected_pins.pop_front();
      if (got.network_led !== want.network_led)
        report($sformatf("result %0d network_led got %b want %b", pins_seen,
                         got.network_led, want.network_led));
      if (got.position_led !== want.position_led)
        report($sformatf("result %0d position_led got %b want %b", pins_seen,
                         got.position_led, want.position_led));
      if (got.power_led !== want.power_led)
        report($sformatf("result %0d power_led got %b want %b", pins_seen,
                         got.power_led, want.power_led));
      pins_seen++;
    endtask

    function int unsigned pending();
      return expected_pins.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  slbc_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  slbc_out_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  led_pin_tracker tracker = new;
  int unsigned    cycles;
  int             burst_left;

  status_led_blink_controller dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, tracker.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) tracker.note_tick(in_data);
      if (out_valid === 1'b1 && out_stall === 1'b0) tracker.check_pins(out_data);
    end
  end

  // receiver back-pressure: segments of no stall, light, heavy and periodic stall
  initial begin
    int mode, len, k;
    out_stall = 1'b0;
    k = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 150);
      repeat (len) begin
        @(negedge clk);
        k++;
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = (k % 5 < 2);
        endcase
      end
    end
  end

  function logic [DATA_W-1:0] reg_mask(logic [2:0] idx);
    case (idx)
      REG_NET_MODE, REG_POS_MODE:                      return DATA_W'(2'b11);
      REG_PWR_EN:                                      return DATA_W'(1'b1);
      REG_QUICK, REG_SLOW_ON, REG_SLOW_OFF, REG_STARTUP: return DATA_W'(16'hFFFF);
      default:                                         return '1;
    endcase
  endfunction

  function logic [TIMER_W-1:0] rand_timing();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TIMER_W'($urandom_range(0, 65535));
      3:       return TIMER_W'($urandom_range(1, 400));
      default: return TIMER_W'(10 * $urandom_range(1, 40));
    endcase
  endfunction

  // APB write then read-back of the same register; starts and ends at negedge
  task write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask, wdata;
    mask  = reg_mask(idx);
    wdata = value & mask;
    if ($urandom_range(0, 1)) wdata = wdata | ($urandom & ~mask);
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.set_reg(idx, wdata);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx <= REG_STARTUP && prdata !== tracker.reg_value(idx))
      tracker.report($sformatf("register %0d read %h want %h", idx, prdata,
                               tracker.reg_value(idx)));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // one tick transfer; sender runs in bursts with random gaps between them
  task send_tick(slbc_in_t t);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    in_data  = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    burst_left--;
  endtask

  task wait_drain();
    in_valid   = 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task randomize_setup();
    write_reg(REG_NET_MODE, DATA_W'($urandom_range(0, 3)));
    write_reg(REG_POS_MODE, DATA_W'($urandom_range(0, 3)));
    write_reg(REG_PWR_EN, DATA_W'($urandom_range(0, 3) != 0));
    write_reg(REG_QUICK, DATA_W'(rand_timing()));
    write_reg(REG_SLOW_ON, DATA_W'(rand_timing()));
    write_reg(REG_SLOW_OFF, DATA_W'(rand_timing()));
    case ($urandom_range(0, 5))
      0:       write_reg(REG_STARTUP, '0);
      1:       write_reg(REG_STARTUP, DATA_W'(16'hFFFF));
      default: write_reg(REG_STARTUP, DATA_W'($urandom_range(0, 30000)));
    endcase
  endtask

  // flag combinations held for random runs so timers reach their compares,
  // with occasional single-tick noise and mid-run drains
  task run_random(int count, int asleep_pct);
    slbc_in_t hold, t;
    int       run;
    run = 0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        hold        = slbc_in_t'(4'($urandom_range(0, 15)));
        hold.asleep = ($urandom_range(0, 99) < asleep_pct);
        run         = $urandom_range(1, 60);
      end
      t = hold;
      if ($urandom_range(0, 9) == 0) t = slbc_in_t'(4'($urandom_range(0, 15)));
      run--;
      if ($urandom_range(0, 59) == 0) wait_drain();
      send_tick(t);
    end
  endtask

  initial begin
    slbc_in_t t;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    tracker.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, power LED disabled
    for (int i = 0; i < 8; i++) begin
      t        = slbc_in_t'(4'(i));
      t.asleep = i[0];
      send_tick(t);
    end
    wait_drain();

    // zero timings make flashing LEDs toggle every tick; mode three flashes
    write_reg(REG_NET_MODE, DATA_W'(MODE_SPARE));
    write_reg(REG_POS_MODE, DATA_W'(MODE_OFF));
    write_reg(REG_PWR_EN, DATA_W'(1'b1));
    write_reg(REG_QUICK, '0);
    write_reg(REG_SLOW_ON, '0);
    write_reg(REG_SLOW_OFF, '0);
    write_reg(REG_STARTUP, '0);
    write_reg(REG_SPARE, $urandom);
    for (int i = 0; i < 16; i++) send_tick(slbc_in_t'(4'(i)));
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      randomize_setup();
      run_random(95, 6);
      wait_drain();
    end

    // maximum timings: full-charge period exceeds the timer range, never toggles
    write_reg(REG_NET_MODE, DATA_W'(MODE_FLASH));
    write_reg(REG_POS_MODE, DATA_W'(MODE_FLASH));
    write_reg(REG_PWR_EN, DATA_W'(1'b1));
    write_reg(REG_QUICK, DATA_W'(16'hFFFF));
    write_reg(REG_SLOW_ON, DATA_W'(16'hFFFF));
    write_reg(REG_SLOW_OFF, DATA_W'(16'hFFFF));
    write_reg(REG_STARTUP, DATA_W'(16'hFFFF));
    t              = '0;
    t.charging     = 1'b1;
    t.battery_full = 1'b1;
    repeat (40) send_tick(t);
    wait_drain();

    // mostly asleep: uptime runs into saturation
    randomize_setup();
    write_reg(REG_PWR_EN, DATA_W'(1'b1));
    run_random(80, 100);

    wait_drain();
    repeat (10) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
